// ===== sv/swfrm_pkg.sv =====
`default_nettype none

package swfrm_pkg;

	localparam int TS_W       = 64;
	localparam int TB_W       = 32;
	localparam int RATE_W     = 24;
	localparam int FRAC_BITS  = 8;
	localparam int FRAMES_W   = 5;
	localparam int WINDOW_DEF = 30;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [TB_W-1:0]   TB_RESET = 32'd1000000000;

	// controller to datapath
	typedef struct packed {
		logic capture;    // store the timestamp, advance write position and count
		logic read;       // fetch the oldest entry, form the numerator product
		logic start_div;  // form elapsed time, launch the divider
		logic load_out;   // move the finished result into the output register
	} swfrm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} swfrm_stat_t;

endpackage

`default_nettype wire

// ===== sv/swfrm_in_if.sv =====
`default_nettype none

interface swfrm_in_if import swfrm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [TS_W-1:0] frame_timestamp;

	modport source (output valid, output frame_timestamp, input ready);
	modport sink   (input valid, input frame_timestamp, output ready);
endinterface

`default_nettype wire

// ===== sv/swfrm_out_if.sv =====
`default_nettype none

interface swfrm_out_if import swfrm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [RATE_W-1:0]   rate_q8;
	logic                rate_valid;
	logic [FRAMES_W-1:0] frames_held;

	modport source (output valid, output rate_q8, output rate_valid, output frames_held,
		input ready);
	modport sink   (input valid, input rate_q8, input rate_valid, input frames_held,
		output ready);
endinterface

`default_nettype wire

// ===== sv/swfrm_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module swfrm_div import swfrm_pkg::*; #(
	parameter int NW = 45
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [TS_W-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);

	localparam int SW = $clog2(NW + 1);

	logic [TS_W-1:0] rem_q;
	logic [NW-1:0]   quo_q;
	logic [TS_W-1:0] den_q;
	logic [SW-1:0]   step_q;
	logic            busy_q;
	logic            done_q;

	logic [TS_W:0] trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(NW);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the remainder stays below the divisor, so it always fits in TS_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? TS_W'(trial - {1'b0, den_q}) : trial[TS_W-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== sv/swfrm_dpath.sv =====
`default_nettype none

module swfrm_dpath import swfrm_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [TB_W-1:0]     cfg_wdata,
	input  wire logic [TS_W-1:0]     stamp,
	input  wire swfrm_cmd_t          cmd,
	output swfrm_stat_t              stat,
	output logic [RATE_W-1:0]        rate_q8,
	output logic                     rate_valid,
	output logic [FRAMES_W-1:0]      frames_held
);

	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam int PW = CW + TB_W;
	localparam int NW = PW + FRAC_BITS;

	logic [TS_W-1:0] ring_q [WINDOW];
	logic [TS_W-1:0] newest_q;
	logic [TS_W-1:0] oldest_q;
	logic [IW-1:0]   wp_q;
	logic [CW-1:0]   cnt_q;
	logic [TB_W-1:0] tb_q;
	logic [PW-1:0]   prod_q;
	logic            ok_q;
	logic [RATE_W-1:0]   rate_q;
	logic                rate_valid_q;
	logic [FRAMES_W-1:0] frames_q;

	logic [IW-1:0]   old_slot;
	logic [CW-1:0]   cnt_m1;
	logic [TS_W-1:0] elapsed;
	logic [NW-1:0]   quo;
	logic [RATE_W-1:0] rate_sat;

	// full window: the next write slot holds the oldest stamp; otherwise slot zero
	assign old_slot   = (cnt_q == CW'(WINDOW)) ? wp_q : '0;
	assign cnt_m1     = cnt_q - CW'(1);
	assign elapsed    = newest_q - oldest_q;
	assign rate_sat   = (|quo[NW-1:RATE_W]) ? RATE_MAX : quo[RATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
			tb_q  <= TB_RESET;
		end else begin
			if (cfg_we) begin
				tb_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				wp_q <= (wp_q == IW'(WINDOW - 1)) ? '0 : wp_q + IW'(1);
				if (cnt_q != CW'(WINDOW)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// timestamp ring
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ring_q[wp_q] <= stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			oldest_q <= ring_q[old_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			newest_q <= stamp;
		end
		if (cmd.read) begin
			prod_q <= {{TB_W{1'b0}}, cnt_m1} * {{CW{1'b0}}, tb_q};
		end
		if (cmd.start_div) begin
			ok_q <= (cnt_q >= CW'(2)) && (elapsed != '0);
		end
		if (cmd.load_out) begin
			rate_q       <= ok_q ? rate_sat : '0;
			rate_valid_q <= ok_q;
			frames_q     <= FRAMES_W'(cnt_q);
		end
	end

	swfrm_div #(
		.NW(NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    ({prod_q, {FRAC_BITS{1'b0}}}),
		.den    (elapsed),
		.done   (stat.div_done),
		.quo    (quo)
	);

	assign rate_q8     = rate_q;
	assign rate_valid  = rate_valid_q;
	assign frames_held = frames_q;

endmodule

`default_nettype wire

// ===== sv/swfrm_ctrl.sv =====
`default_nettype none

module swfrm_ctrl import swfrm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire swfrm_stat_t stat,
	output swfrm_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SETUP,
		S_DIV,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == S_IDLE);
		cmd.capture   = in_ready && in_valid;
		cmd.read      = (state_q == S_READ);
		cmd.start_div = (state_q == S_SETUP);
		cmd.load_out  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ:  state_q <= S_SETUP;
				S_SETUP: state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/sliding_window_frame_rate_meter_core.sv =====
`default_nettype none

// Frame rate meter over a sliding window of the last WINDOW frame timestamps.
// Each transaction on frames carries one 64-bit timestamp; each produces one
// transaction on rates with the rate in frames per second (unsigned, 8 fraction
// bits, saturating at all ones), a rate_valid flag and the number of stamps held.
// Rate is (held-1) * time_base_hz * 256 / (newest - oldest), truncated; with
// fewer than two stamps or zero elapsed time it reads 0 with rate_valid low.
// One transaction is in flight at a time: after acceptance the controller steps
// through S_READ, S_SETUP, S_DIV and S_FINISH and loads the result, with NW =
// $clog2(WINDOW+1) + 40 quotient bits from the restoring divider, which retires
// one quotient bit per cycle. frames is ready again right after the result is
// loaded, even if rates has not taken it yet; a result still held on rates
// delays the next load and with it the input.
// time_base_hz is written through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce; it resets to 1000000000 (nanosecond stamps).
module sliding_window_frame_rate_meter_core import swfrm_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [TB_W-1:0] cfg_wdata,
	swfrm_in_if.sink             frames,
	swfrm_out_if.source          rates
);

	swfrm_cmd_t  cmd;
	swfrm_stat_t stat;

	// sequence the transaction: capture, read oldest, divide, hand off
	swfrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frames.valid),
		.in_ready  (frames.ready),
		.out_valid (rates.valid),
		.out_ready (rates.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// ring, pointers, time base, product, divider and output register
	swfrm_dpath #(
		.WINDOW(WINDOW)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.stamp       (frames.frame_timestamp),
		.cmd         (cmd),
		.stat        (stat),
		.rate_q8     (rates.rate_q8),
		.rate_valid  (rates.rate_valid),
		.frames_held (rates.frames_held)
	);

	// hold off new transactions while one is being processed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		frames.valid && frames.ready |=> !frames.ready)
		else $error("frames ready right after an accepted transaction");

	// an invalid rate always reads as zero
	a_invalid_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rates.valid && !rates.rate_valid |-> rates.rate_q8 == '0)
		else $error("nonzero rate with rate_valid low");

	// the divider finishes only inside a transaction
	a_div_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !frames.ready)
		else $error("divider done while idle");

endmodule

`default_nettype wire
